@@ rtl/core/hierarchical_bitmap_price_level_index_defines.svh @@
// Assertion macros for the price level index.
`ifndef HIERARCHICAL_BITMAP_PRICE_LEVEL_INDEX_DEFINES_SVH
`define HIERARCHICAL_BITMAP_PRICE_LEVEL_INDEX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HBPLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbpli: check failed");

// next-cycle implication
`define HBPLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbpli: check failed");

`endif

@@ rtl/core/hbpli_pkg.sv @@
// Shared constants and types of the price level index.
package hbpli_pkg;

  localparam int PRICE_BITS  = 12;
  localparam int WORD_BITS   = 64;
  localparam int COUNT_BITS  = 16;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int LEAF_IDX_W  = PRICE_BITS - BIT_IDX_W;
  localparam int LEAF_ADDR_W = LEAF_IDX_W + 1;
  localparam int CNT_ADDR_W  = PRICE_BITS + 1;
  localparam int LEAF_DEPTH  = 1 << LEAF_ADDR_W;
  localparam int CNT_DEPTH   = 1 << CNT_ADDR_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_QSUM,
    S_QLEAF
  } state_t;

  typedef struct packed {
    logic                 any;
    logic [BIT_IDX_W-1:0] pos;
  } penc_res_t;

endpackage

@@ rtl/core/hbpli_penc.sv @@
// Shared priority encoder: highest or lowest set bit of a word.
module hbpli_penc import hbpli_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 low,
  output penc_res_t            res
);

  logic [WORD_BITS-1:0] src;
  logic [WORD_BITS-1:0] w;
  logic [BIT_IDX_W-1:0] top;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      src[k] = low ? word[WORD_BITS-1-k] : word[k];
    end
    // binary search: upper half nonzero sets this position bit
    w   = src;
    top = '0;
    for (int l = BIT_IDX_W - 1; l >= 0; l--) begin
      if ((w >> (1 << l)) != '0) begin
        top[l] = 1'b1;
        w      = w >> (1 << l);
      end
    end
    res.any = |word;
    res.pos = low ? (BIT_IDX_W'(WORD_BITS - 1) - top) : top;
  end

endmodule

@@ rtl/core/hierarchical_bitmap_price_level_index.sv @@
// Top level of the two-sided price level index with two-level bitmaps.
//
//   channel   signals                                    handshake
//   command   func, side, price                          start & !busy
//   result    status, found, best_price, level_count     done, one cycle
//
// Add, remove and unknown codes pass through the execute state to done; a
// query through the summary and then the leaf state, or only the summary
// state on an empty side (summary encode, then leaf read and encode through
// the one encoder). The count store has one read port, used at accept, and
// one write port, written back in the cycle after accept. A new command may
// start in the cycle that done is high. After reset a clearing pass walks the
// 8192 counts, one a cycle, with busy high. The receiver cannot stall results.
`include "hierarchical_bitmap_price_level_index_defines.svh"

module hierarchical_bitmap_price_level_index import hbpli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic                  side,
  input  logic [PRICE_BITS-1:0] price,
  output logic                  done,
  output logic [1:0]            status,
  output logic                  found,
  output logic [PRICE_BITS-1:0] best_price,
  output logic [COUNT_BITS-1:0] level_count
);

  state_t state, state_next;
  logic [CNT_ADDR_W-1:0] clr_addr;

  logic [1:0]            func_r;
  logic                  side_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [LEAF_IDX_W-1:0] li_r, li_next;

  logic                  done_next;
  status_t               status_next;
  logic                  found_next;
  logic [PRICE_BITS-1:0] best_next;
  logic [COUNT_BITS-1:0] lc_next;

  logic [WORD_BITS-1:0]  sum_words [2];
  logic                  sum_we;
  logic [WORD_BITS-1:0]  sum_wd;

  logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  cnt_we;
  logic [CNT_ADDR_W-1:0] cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;

  logic [WORD_BITS-1:0]   leaf_mem [LEAF_DEPTH];
  logic [LEAF_DEPTH-1:0]  leaf_valid;
  logic [WORD_BITS-1:0]   leaf_rd;
  logic                   leaf_vrd;
  logic                   leaf_we;
  logic [LEAF_ADDR_W-1:0] leaf_ra;
  logic [WORD_BITS-1:0]   leaf_wd;

  logic [WORD_BITS-1:0]  leaf_word, bit_mask, sum_mask, cur_sum, enc_word, leaf_clr;
  logic [LEAF_IDX_W-1:0] leaf_idx;
  penc_res_t             enc;

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  assign leaf_word = leaf_vrd ? leaf_rd : '0;
  assign leaf_idx  = price_r[PRICE_BITS-1:BIT_IDX_W];
  assign bit_mask  = WORD_BITS'(1) << price_r[BIT_IDX_W-1:0];
  assign sum_mask  = WORD_BITS'(1) << leaf_idx;
  assign cur_sum   = sum_words[side_r];
  assign leaf_clr  = leaf_word & ~bit_mask;
  assign enc_word  = (state == S_QLEAF) ? leaf_word : cur_sum;

  hbpli_penc u_penc (
    .word (enc_word),
    .low  (side_r),
    .res  (enc)
  );

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    status_next = ST_OK;
    found_next  = 1'b0;
    best_next   = '0;
    lc_next     = '0;
    li_next     = li_r;
    cnt_we      = 1'b0;
    cnt_wa      = {side_r, price_r};
    cnt_wd      = '0;
    leaf_we     = 1'b0;
    leaf_wd     = '0;
    leaf_ra     = {side, price[PRICE_BITS-1:BIT_IDX_W]};
    sum_we      = 1'b0;
    sum_wd      = cur_sum;
    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_addr;
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = (func == FN_QUERY) ? S_QSUM : S_EXEC;
      end
      S_EXEC: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        case (func_r)
          FN_ADD: begin
            if (cnt_rd == COUNT_MAX) begin
              status_next = ST_FULL;
              lc_next     = cnt_rd;
            end else begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd + COUNT_BITS'(1);
              lc_next = cnt_rd + COUNT_BITS'(1);
              leaf_we = 1'b1;
              leaf_wd = leaf_word | bit_mask;
              sum_we  = 1'b1;
              sum_wd  = cur_sum | sum_mask;
            end
          end
          FN_REMOVE: begin
            if (cnt_rd == '0) begin
              status_next = ST_EMPTY;
            end else begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd - COUNT_BITS'(1);
              lc_next = cnt_rd - COUNT_BITS'(1);
              if (cnt_rd == COUNT_BITS'(1)) begin
                leaf_we = 1'b1;
                leaf_wd = leaf_clr;
                if (leaf_clr == '0) begin
                  sum_we = 1'b1;
                  sum_wd = cur_sum & ~sum_mask;
                end
              end
            end
          end
          default: begin
            // unknown code: all-zero result, no update
          end
        endcase
      end
      S_QSUM: begin
        leaf_ra = {side_r, enc.pos};
        li_next = enc.pos;
        if (!enc.any) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_QLEAF;
        end
      end
      S_QLEAF: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        found_next = enc.any;
        best_next  = enc.any ? {li_r, enc.pos} : '0;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + CNT_ADDR_W'(1);
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func;
      side_r  <= side;
      price_r <= price;
    end
    li_r <= li_next;
    if (done_next) begin
      status      <= status_next;
      found       <= found_next;
      best_price  <= best_next;
      level_count <= lc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_words[0] <= '0;
      sum_words[1] <= '0;
    end else if (sum_we) begin
      sum_words[side_r] <= sum_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_valid <= '0;
    end else if (leaf_we) begin
      leaf_valid[{side_r, leaf_idx}] <= 1'b1;
    end
  end

  // count store, read at the command address
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[{side, price}];
  end

  // leaf word store; words never written read as zero
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[{side_r, leaf_idx}] <= leaf_wd;
    leaf_rd  <= leaf_mem[leaf_ra];
    leaf_vrd <= leaf_valid[leaf_ra];
  end

  `HBPLI_ASSERT_NOW(a_done_when_idle, done, !busy)
  `HBPLI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `HBPLI_ASSERT_NEXT(a_done_single, done, !done)
  `HBPLI_ASSERT_NOW(a_found_clean, done && found, status == ST_OK && level_count == '0)

endmodule
